@@ rtl/core/sirs_pkg.sv @@
// ----------------------------------------------------------------------------
// sirs_pkg
// Shared types and constants for the signed integer to radix symbols core:
// register indices, sign bytes, digit widths and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sirs_pkg;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COUNT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Symbols carried by one alphabet register
  localparam int unsigned SYMS_PER_REG = 8;

  // Symbol bytes and digits
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [SYM_W-1:0]   SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0]   SYM_PLUS  = 8'h2B;
  localparam logic [COUNT_W-1:0] MIN_RADIX = 5'd2;

  // Dividend bits retired by the divider in one cycle
  localparam int unsigned CHUNK_BITS = 8;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture sign and magnitude of a new value
    logic div_step;    // one chunk of long division
    logic div_last;    // final chunk: push the digit, keep the quotient
    logic emit_sign;   // drive a minus sign beat
    logic emit_digit;  // drive the top digit's symbol and pop it
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic alpha_ok;    // alphabet passes all checks
    logic neg;         // value being converted is negative
    logic mag_small;   // working magnitude is below the radix
    logic one_left;    // exactly one digit remains on the stack
  } sts_t;

endpackage

@@ rtl/core/signed_integer_to_radix_symbols_core.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_symbols_core
// Writes a signed integer as symbol bytes in the radix set by its alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   Program symbol_count (cfg_index 0), symbols_low (1) and symbols_high (2)
//   through cfg_we/cfg_index/cfg_wdata while the core is idle.
//   A value is taken on in_value at a clock edge with start high and busy low.
//   The run comes out as one beat per cycle on out_symbol/out_last, flagged
//   by out_valid: a minus sign first for a negative value, then the digits
//   most significant first; out_last marks the final beat. The receiver
//   cannot stall; every beat is taken in the cycle it is shown.
//   Sequence: each digit is formed by long division of the whole working
//   magnitude by the radix, 8 dividend bits a cycle; then the sign and digit
//   beats are formed, one per cycle, and busy stays high until the last
//   digit beat is formed. Beats leave through an output register, in the
//   cycle after the cycle that forms them.
//   Start is ignored under a rejected alphabet: busy stays low, no beats.
//   Reset zeroes the configuration (empty alphabet) and idles the core.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_symbols_core #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [VALUE_BITS-1:0]       in_value,
  output logic                               out_valid,
  output logic [sirs_pkg::SYM_W-1:0]         out_symbol,
  output logic                               out_last
);

  sirs_pkg::cmd_t cmd;
  sirs_pkg::sts_t sts;

  // Sequencer
  sirs_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // Registers, divider, digit stack
  sirs_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_value   (in_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

endmodule

@@ rtl/core/sirs_dp.sv @@
// ----------------------------------------------------------------------------
// sirs_dp
// Datapath: configuration registers, alphabet check, chunked long divider
// by the radix, digit stack and the registered symbol outputs.
// ----------------------------------------------------------------------------
module sirs_dp #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic signed [VALUE_BITS-1:0]         in_value,
  input  sirs_pkg::cmd_t                       cmd,
  output sirs_pkg::sts_t                       sts,
  output logic [sirs_pkg::SYM_W-1:0]           out_symbol,
  output logic                                 out_last
);

  localparam int STEPS  = (VALUE_BITS + sirs_pkg::CHUNK_BITS - 1) / sirs_pkg::CHUNK_BITS;
  localparam int DW     = STEPS * sirs_pkg::CHUNK_BITS;
  localparam int STK_W  = VALUE_BITS * sirs_pkg::DIGIT_W;
  localparam int NDIG_W = $clog2(VALUE_BITS + 1);

  logic [sirs_pkg::COUNT_W-1:0]  count_r;
  logic [sirs_pkg::SYM_W-1:0]    sym_r [MAX_SYMBOLS];

  logic                          neg_r;
  logic [DW-1:0]                 work_r;
  logic [sirs_pkg::DIGIT_W-1:0]  rem_r;
  logic [STK_W-1:0]              stack_r;
  logic [NDIG_W-1:0]             ndig_r;
  logic [sirs_pkg::SYM_W-1:0]    out_symbol_r;
  logic                          out_last_r;

  logic                          alpha_ok;
  logic [VALUE_BITS-1:0]         in_u;
  logic [VALUE_BITS-1:0]         mag;
  logic [DW-1:0]                 div_work;
  logic [sirs_pkg::DIGIT_W-1:0]  div_rem;
  logic [sirs_pkg::SYM_W-1:0]    sel_sym;

  // Configuration registers; bytes beyond the stored alphabet are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < MAX_SYMBOLS; k++) sym_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sirs_pkg::REG_SYMBOL_COUNT: begin
          count_r <= cfg_wdata[sirs_pkg::COUNT_W-1:0];
        end
        sirs_pkg::REG_SYMBOLS_LOW: begin
          for (int k = 0; k < MAX_SYMBOLS; k++)
            if (k < sirs_pkg::SYMS_PER_REG)
              sym_r[k] <= cfg_wdata[(k % sirs_pkg::SYMS_PER_REG)*sirs_pkg::SYM_W +: sirs_pkg::SYM_W];
        end
        sirs_pkg::REG_SYMBOLS_HIGH: begin
          for (int k = 0; k < MAX_SYMBOLS; k++)
            if (k >= sirs_pkg::SYMS_PER_REG)
              sym_r[k] <= cfg_wdata[(k % sirs_pkg::SYMS_PER_REG)*sirs_pkg::SYM_W +: sirs_pkg::SYM_W];
        end
        default: begin
        end
      endcase
    end
  end

  // Alphabet check: radix in range, no sign bytes, no duplicates in use
  always_comb begin
    alpha_ok = (count_r >= sirs_pkg::MIN_RADIX) &&
               (count_r <= sirs_pkg::COUNT_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (sirs_pkg::COUNT_W'(i) < count_r) begin
        if (sym_r[i] == sirs_pkg::SYM_MINUS || sym_r[i] == sirs_pkg::SYM_PLUS)
          alpha_ok = 1'b0;
        for (int j = i + 1; j < MAX_SYMBOLS; j++)
          if (sirs_pkg::COUNT_W'(j) < count_r && sym_r[i] == sym_r[j])
            alpha_ok = 1'b0;
      end
    end
  end

  // Magnitude; the most negative value wraps to its true magnitude unsigned
  assign in_u = in_value;
  assign mag  = in_u[VALUE_BITS-1] ? (~in_u + VALUE_BITS'(1)) : in_u;

  // One chunk of restoring division by the radix, MSB first
  always_comb begin
    logic [sirs_pkg::DIGIT_W:0]      t;
    logic [sirs_pkg::DIGIT_W-1:0]    r;
    logic [sirs_pkg::CHUNK_BITS-1:0] q;
    r = rem_r;
    q = '0;
    for (int i = 0; i < sirs_pkg::CHUNK_BITS; i++) begin
      t = {r, work_r[DW-1-i]};
      if (t >= count_r) begin
        r = sirs_pkg::DIGIT_W'(t - count_r);
        q[sirs_pkg::CHUNK_BITS-1-i] = 1'b1;
      end else begin
        r = t[sirs_pkg::DIGIT_W-1:0];
      end
    end
    div_rem  = r;
    div_work = (work_r << sirs_pkg::CHUNK_BITS) | DW'(q);
  end

  // Symbol for the digit on top of the stack
  always_comb begin
    sel_sym = '0;
    for (int k = 0; k < MAX_SYMBOLS; k++)
      if (sirs_pkg::DIGIT_W'(k) == stack_r[sirs_pkg::DIGIT_W-1:0])
        sel_sym = sym_r[k];
  end

  // Digit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndig_r <= '0;
    end else if (cmd.load) begin
      ndig_r <= '0;
    end else if (cmd.div_step && cmd.div_last) begin
      ndig_r <= ndig_r + NDIG_W'(1);
    end else if (cmd.emit_digit) begin
      ndig_r <= ndig_r - NDIG_W'(1);
    end
  end

  // Working magnitude, remainder, digit stack and output beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= in_u[VALUE_BITS-1];
      work_r <= DW'(mag);
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      work_r <= div_work;
      rem_r  <= cmd.div_last ? '0 : div_rem;
      if (cmd.div_last)
        stack_r <= (stack_r << sirs_pkg::DIGIT_W) | STK_W'(div_rem);
    end
    if (cmd.emit_sign) begin
      out_symbol_r <= sirs_pkg::SYM_MINUS;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_symbol_r <= sel_sym;
      out_last_r   <= (ndig_r == NDIG_W'(1));
      stack_r      <= stack_r >> sirs_pkg::DIGIT_W;
    end
  end

  assign sts.alpha_ok  = alpha_ok;
  assign sts.neg       = neg_r;
  assign sts.mag_small = (work_r < DW'(count_r));
  assign sts.one_left  = (ndig_r == NDIG_W'(1));

  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

@@ rtl/core/sirs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sirs_ctrl
// Controller: sequences the chunked divisions per digit, then the optional
// minus sign and the digits most significant first, one beat per cycle.
// ----------------------------------------------------------------------------
module sirs_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sirs_pkg::sts_t  sts,
  output sirs_pkg::cmd_t  cmd,
  output logic            out_valid
);

  localparam int STEPS  = (VALUE_BITS + sirs_pkg::CHUNK_BITS - 1) / sirs_pkg::CHUNK_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                final_r, final_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                is_final;
  logic                last_chunk;

  // Whether the digit in progress is the most significant one
  assign is_final   = (step_r == '0) ? sts.mag_small : final_r;
  assign last_chunk = (step_r == STEP_W'(STEPS - 1));

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    final_nxt     = final_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && sts.alpha_ok) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = last_chunk;
        final_nxt    = is_final;
        if (last_chunk) begin
          step_nxt = '0;
          if (is_final)
            state_nxt = sts.neg ? ST_SIGN : ST_DIGITS;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_DIGITS;
      end
      ST_DIGITS: begin
        cmd.emit_digit = 1'b1;
        out_valid_nxt  = 1'b1;
        if (sts.one_left)
          state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
